/* src/mandelbrot_escape_pixel_top_assert.svh */
// ============================================================================
// mandelbrot_escape_pixel_top_assert.svh
// Assertion macros shared by the checker of the escape-time pixel unit.
// ============================================================================
`ifndef MANDELBROT_ESCAPE_PIXEL_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define MEP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("mep assertion failed");

// Next-cycle implication, also checked through reset.
`define MEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error("mep assertion failed");

`endif

/* src/mep_pkg.sv */
// ============================================================================
// mep_pkg
// Shared types and constants of the escape-time pixel unit.
// ============================================================================
package mep_pkg;

    localparam int COORD_W     = 36;             // origin and step registers
    localparam int IDX_W       = 8;              // pixel row / column
    localparam int C_W         = COORD_W + IDX_W + 1; // exact c coordinate
    localparam int ITER_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int FRAC_BITS_DEF = 28;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_origin;
        logic signed [COORD_W-1:0] y_origin;
        logic signed [COORD_W-1:0] x_step;
        logic signed [COORD_W-1:0] y_step;
    } t_coord_cfg;

    typedef struct packed {
        logic signed [C_W-1:0] cr;
        logic signed [C_W-1:0] ci;
    } t_point;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD
    } t_back_state;

endpackage

/* src/mandelbrot_escape_pixel_top.sv */
// ============================================================================
// mandelbrot_escape_pixel_top
// Escape-time evaluation of one Mandelbrot pixel per command.
// ============================================================================
// Issue a pixel by raising start with pixel_row and pixel_col while busy is
// low; the command transfers on that clock edge. The unit forms
// c = (x_origin + col*x_step) + i(y_origin + row*y_step) exactly in signed
// fixed point with FRAC_BITS fraction bits, then iterates z <- z*z + c from
// zero until the count reaches the iteration limit, a part of z reaches 4.0
// in magnitude, or |z|^2 reaches 16.0. Each result shows on o_iteration_count
// and o_escaped_white for exactly one cycle, marked by o_result_strobe; the
// receiver cannot stall it, so sample it on that cycle. Results come out in
// command order. The iteration unit works on one pixel at a time; each
// iteration runs a multiply state (three products of z) and an add state
// (radius compare and z update). The limit and the 4.0 bound on a part of z
// end a pixel in the multiply state, the radius test in the add state. The
// front stage and a two-entry queue take further commands while a pixel is
// iterating, so busy rises only once both are full.
// Write configuration through the cfg channel (ready is always high) only
// while no pixel is in flight; indexes beyond the register list are dropped.
// ============================================================================
module mandelbrot_escape_pixel_top #(
    parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel command
    input  logic                            start,
    output logic                            busy,
    input  logic [mep_pkg::IDX_W-1:0]       i_pixel_row,
    input  logic [mep_pkg::IDX_W-1:0]       i_pixel_col,
    // result
    output logic                            o_result_strobe,
    output logic [mep_pkg::ITER_W-1:0]      o_iteration_count,
    output logic                            o_escaped_white,
    // configuration write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mep_pkg::COORD_W-1:0]     i_cfg_data
);
    import mep_pkg::*;

    t_coord_cfg         r_cfg;
    logic [ITER_W-1:0]  r_max_iter;
    logic               w_cfg_write;

    logic               w_push;
    logic               w_pop;
    t_point             w_front_point;
    t_point             w_queue_point;
    t_q_status          w_q_status;

    // Registers always take a transfer
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_origin <= -COORD_W'(36'sd536870912);
            r_cfg.y_origin <= -COORD_W'(36'sd335544320);
            r_cfg.x_step   <= COORD_W'(36'sd2621440);
            r_cfg.y_step   <= COORD_W'(36'sd2621440);
            r_max_iter     <= ITER_W'(8'd50);
        end else if (w_cfg_write) begin
            unique case (i_cfg_index)
                CFG_X_ORIGIN: r_cfg.x_origin <= i_cfg_data;
                CFG_Y_ORIGIN: r_cfg.y_origin <= i_cfg_data;
                CFG_X_STEP:   r_cfg.x_step   <= i_cfg_data;
                CFG_Y_STEP:   r_cfg.y_step   <= i_cfg_data;
                CFG_MAX_ITER: r_max_iter     <= i_cfg_data[ITER_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Front: take the command, form c, hold it until the queue has room
    mep_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .i_cfg       (r_cfg),
        .i_q_status  (w_q_status),
        .o_busy      (busy),
        .o_push      (w_push),
        .o_point     (w_front_point)
    );

    // Queue: decouple command intake from the iteration loop
    mep_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_point  (w_front_point),
        .i_pop    (w_pop),
        .o_point  (w_queue_point),
        .o_status (w_q_status)
    );

    // Back: iterate one point at a time and emit the one-cycle result
    mep_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_max_iter        (r_max_iter),
        .i_point           (w_queue_point),
        .i_q_status        (w_q_status),
        .o_pop             (w_pop),
        .o_result_strobe   (o_result_strobe),
        .o_iteration_count (o_iteration_count),
        .o_escaped_white   (o_escaped_white)
    );

endmodule

/* src/mep_front.sv */
// ============================================================================
// mep_front
// Accepts pixel commands and forms the point c; hands it to the queue.
// ============================================================================
module mep_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mep_pkg::IDX_W-1:0]   i_pixel_row,
    input  logic [mep_pkg::IDX_W-1:0]   i_pixel_col,
    input  mep_pkg::t_coord_cfg         i_cfg,
    input  mep_pkg::t_q_status          i_q_status,
    output logic                        o_busy,
    output logic                        o_push,
    output mep_pkg::t_point             o_point
);
    import mep_pkg::*;

    logic                  r_valid;
    logic                  n_valid;
    t_point                r_point;
    logic signed [C_W-1:0] w_cr;
    logic signed [C_W-1:0] w_ci;
    logic                  w_accept;

    // Exact coordinate: origin + index * step
    assign w_cr = $signed({{(C_W-COORD_W){i_cfg.x_origin[COORD_W-1]}}, i_cfg.x_origin})
                + $signed({1'b0, i_pixel_col}) * i_cfg.x_step;
    assign w_ci = $signed({{(C_W-COORD_W){i_cfg.y_origin[COORD_W-1]}}, i_cfg.y_origin})
                + $signed({1'b0, i_pixel_row}) * i_cfg.y_step;

    assign o_busy   = r_valid && i_q_status.full;
    assign o_push   = r_valid && !i_q_status.full;
    assign w_accept = i_start && !o_busy;
    assign o_point  = r_point;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_point.cr <= w_cr;
            r_point.ci <= w_ci;
        end
    end

endmodule

/* src/mep_queue.sv */
// ============================================================================
// mep_queue
// Short first-in first-out queue of points between front and back.
// ============================================================================
module mep_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mep_pkg::t_point     i_point,
    input  logic                i_pop,
    output mep_pkg::t_point     o_point,
    output mep_pkg::t_q_status  o_status
);
    import mep_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_point             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_status.full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign w_push  = i_push && !o_status.full;
    assign w_pop   = i_pop && !o_status.empty;
    assign o_point = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_point;
        end
    end

endmodule

/* src/mep_back.sv */
// ============================================================================
// mep_back
// Runs z <- z*z + c for one point at a time and registers the result.
// ============================================================================
module mep_back #(
    parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mep_pkg::ITER_W-1:0]  i_max_iter,
    input  mep_pkg::t_point             i_point,
    input  mep_pkg::t_q_status          i_q_status,
    output logic                        o_pop,
    output logic                        o_result_strobe,
    output logic [mep_pkg::ITER_W-1:0]  o_iteration_count,
    output logic                        o_escaped_white
);
    import mep_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int ZW  = ((C_W > F + 6) ? C_W : F + 6) + 1;  // holds any updated z
    localparam int MW  = F + 3;                              // |z| < 4.0 in signed form
    localparam int SQW = 2 * F + 4;                          // square below 16.0
    localparam int XW  = 2 * F + 5;                          // signed cross product

    localparam logic signed [ZW-1:0] BOUND =
        {{(ZW-F-3){1'b0}}, 1'b1, {(F+2){1'b0}}};

    t_back_state            r_state;
    t_back_state            n_state;
    logic signed [C_W-1:0]  r_cr;
    logic signed [C_W-1:0]  r_ci;
    logic signed [ZW-1:0]   r_zr;
    logic signed [ZW-1:0]   r_zi;
    logic signed [ZW-1:0]   n_zr;
    logic signed [ZW-1:0]   n_zi;
    logic [ITER_W-1:0]      r_count;
    logic [ITER_W-1:0]      n_count;
    logic [SQW-1:0]         r_rr;
    logic [SQW-1:0]         r_ii;
    logic signed [XW-1:0]   r_ri;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [ITER_W-1:0]      r_out_count;
    logic                   r_out_white;
    logic                   w_load;
    logic                   w_mul_en;

    logic signed [MW-1:0]     w_zr_t;
    logic signed [MW-1:0]     w_zi_t;
    logic signed [2*MW-1:0]   w_prr;
    logic signed [2*MW-1:0]   w_pii;
    logic signed [2*MW-1:0]   w_pri;
    logic [SQW:0]             w_sum;
    logic [F+3:0]             w_sr;
    logic [F+3:0]             w_si;
    logic signed [F+4:0]      w_cross;
    logic                     w_zr_in;
    logic                     w_zi_in;

    function automatic logic in_range(input logic signed [ZW-1:0] v);
        return (v < BOUND) && (v > -BOUND);
    endfunction

    assign w_zr_in = in_range(r_zr);
    assign w_zi_in = in_range(r_zi);

    // Products are used only while both parts are inside the bound
    assign w_zr_t = r_zr[MW-1:0];
    assign w_zi_t = r_zi[MW-1:0];
    assign w_prr  = w_zr_t * w_zr_t;
    assign w_pii  = w_zi_t * w_zi_t;
    assign w_pri  = w_zr_t * w_zi_t;

    assign w_sum   = {1'b0, r_rr} + {1'b0, r_ii};
    assign w_sr    = r_rr[SQW-1:F];
    assign w_si    = r_ii[SQW-1:F];
    assign w_cross = r_ri[XW-1:F];   // arithmetic shift: floor toward minus infinity

    assign o_result_strobe   = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_escaped_white   = r_out_white;

    always_comb begin
        n_state     = r_state;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_count     = r_count;
        n_out_valid = 1'b0;
        w_load      = 1'b0;
        w_mul_en    = 1'b0;
        o_pop       = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    w_load  = 1'b1;
                    n_zr    = '0;
                    n_zi    = '0;
                    n_count = '0;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                if ((r_count == i_max_iter) || !w_zr_in || !w_zi_in) begin
                    n_out_valid = 1'b1;
                    n_state     = BK_IDLE;
                end else begin
                    w_mul_en = 1'b1;
                    n_state  = BK_ADD;
                end
            end
            BK_ADD: begin
                if (w_sum[SQW]) begin
                    n_out_valid = 1'b1;
                    n_state     = BK_IDLE;
                end else begin
                    n_zr = $signed({{(ZW-F-4){1'b0}}, w_sr})
                         - $signed({{(ZW-F-4){1'b0}}, w_si})
                         + $signed({{(ZW-C_W){r_cr[C_W-1]}}, r_cr});
                    n_zi = $signed({{(ZW-F-6){w_cross[F+4]}}, w_cross, 1'b0})
                         + $signed({{(ZW-C_W){r_ci[C_W-1]}}, r_ci});
                    n_count = r_count + 1'b1;
                    n_state = BK_MUL;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_count <= n_count;
        if (w_load) begin
            r_cr <= i_point.cr;
            r_ci <= i_point.ci;
        end
        if (w_mul_en) begin
            r_rr <= w_prr[SQW-1:0];
            r_ii <= w_pii[SQW-1:0];
            r_ri <= w_pri[XW-1:0];
        end
        if (n_out_valid) begin
            r_out_count <= r_count;
            r_out_white <= (r_count < i_max_iter);
        end
    end

endmodule

/* src/mep_check.sv */
// ============================================================================
// mep_check
// Port-level checks on the escape-time pixel unit, bound to the top level.
// ============================================================================
`include "mandelbrot_escape_pixel_top_assert.svh"

module mep_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       o_result_strobe,
    input  logic [7:0] o_iteration_count,
    input  logic       o_escaped_white
);

    // Reset leaves no result and no back-pressure
    `MEP_ASSERT_NEXT(a_rst_no_strobe, !i_rst_n, !o_result_strobe)
    `MEP_ASSERT_NEXT(a_rst_not_busy, !i_rst_n, !busy)

    // Every pixel is loaded in idle and checked in the multiply state, so results never abut
    `MEP_ASSERT_NEXT(a_strobe_gap, i_rst_n && o_result_strobe, !o_result_strobe)

    // z starts at zero, so an escape always follows at least one iteration
    `MEP_ASSERT_IMP(a_white_counted, o_result_strobe && o_escaped_white,
                    o_iteration_count != 8'd0)

endmodule

bind mandelbrot_escape_pixel_top mep_check u_mep_check (.*);

/* test/mandelbrot_escape_pixel_top_tb.sv */
// ============================================================================
// mandelbrot_escape_pixel_top_tb
// Self-checking bench for the escape-time pixel unit.
// ============================================================================
// Drives pixel commands through the start/busy port and programs the view
// through the cfg channel. It predicts each pixel's iteration count and
// white flag from its own copy of the registers and checks every strobed
// result, in order, against the oldest prediction. A directed opening covers
// the corners of the view, bounded orbits, zero / one / full iteration
// limits, spare register indexes and extreme coordinates. Random phases
// follow, mostly views placed near the set boundary, with sender idling.
// ============================================================================
module mandelbrot_escape_pixel_top_tb;
    import mep_pkg::*;

    localparam int     FRAC          = FRAC_BITS_DEF;
    localparam int     RAND_PHASES   = 10;
    localparam int     PHASE_PIXELS  = 125;
    // Give leftover results time to show after the last drain.
    localparam int     SETTLE_CYCLES = 600;
    localparam longint CYCLE_LIMIT   = 3_000_000;

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_W - 1));

    // Register values after reset: view -2.0 .. 0.5, -1.25 .. 1.25, limit 50
    localparam longint RESET_X_ORIGIN = -536870912;
    localparam longint RESET_Y_ORIGIN = -335544320;
    localparam longint RESET_STEP     = 2621440;
    localparam int     RESET_LIMIT    = 50;

    typedef struct packed {
        logic [ITER_W-1:0] count;
        logic              white;
    } t_escape_result;

    // ------------------------------------------------------------------------
    // Scoreboard: register shadow, escape-time predictor, expected results
    // ------------------------------------------------------------------------
    class t_escape_scoreboard;
        logic signed [63:0] x_org;
        logic signed [63:0] y_org;
        logic signed [63:0] x_inc;
        logic signed [63:0] y_inc;
        logic [ITER_W-1:0]  iter_limit;
        t_escape_result     escape_q[$];
        int                 mismatch_count;

        function new();
            x_org          = RESET_X_ORIGIN;
            y_org          = RESET_Y_ORIGIN;
            x_inc          = RESET_STEP;
            y_inc          = RESET_STEP;
            iter_limit     = ITER_W'(RESET_LIMIT);
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
            case (idx)
                CFG_X_ORIGIN: x_org = $signed(data);
                CFG_Y_ORIGIN: y_org = $signed(data);
                CFG_X_STEP:   x_inc = $signed(data);
                CFG_Y_STEP:   y_inc = $signed(data);
                CFG_MAX_ITER: iter_limit = data[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        function t_escape_result predict_escape(logic [IDX_W-1:0] row,
                                                logic [IDX_W-1:0] col);
            logic signed [127:0] cr, ci, zr, zi, rr, ii, xprod;
            logic signed [127:0] bound, radius_sq;
            int                  n;
            t_escape_result      res;
            bound     = 128'sd4 <<< FRAC;
            radius_sq = 128'sd16 <<< (2 * FRAC);
            cr = x_org + $signed({1'b0, col}) * x_inc;
            ci = y_org + $signed({1'b0, row}) * y_inc;
            zr = 0;
            zi = 0;
            n  = 0;
            while (n < iter_limit) begin
                // a part at 4.0 or beyond has escaped; squares stay exact below it
                if ((zr < 0 ? -zr : zr) >= bound || (zi < 0 ? -zi : zi) >= bound)
                    break;
                rr = zr * zr;
                ii = zi * zi;
                if (rr + ii >= radius_sq)
                    break;
                // arithmetic shift floors toward minus infinity
                xprod = (zr * zi) >>> FRAC;
                zr    = (rr >>> FRAC) - (ii >>> FRAC) + cr;
                zi    = 2 * xprod + ci;
                n++;
            end
            res.count = ITER_W'(n);
            res.white = (n < iter_limit);
            return res;
        endfunction

        function void note_pixel(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
            escape_q.push_back(predict_escape(row, col));
        endfunction

        function void check_result(logic [ITER_W-1:0] count, logic white);
            t_escape_result want;
            if (escape_q.size() == 0) begin
                $error("result with nothing pending: iteration_count %0d escaped_white %0d",
                       count, white);
                mismatch_count++;
                return;
            end
            want = escape_q.pop_front();
            if (count !== want.count) begin
                $error("iteration_count mismatch: expected %0d, actual %0d",
                       want.count, count);
                mismatch_count++;
            end
            if (white !== want.white) begin
                $error("escaped_white mismatch: expected %0d, actual %0d",
                       want.white, white);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return escape_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT, signals
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [IDX_W-1:0]      i_pixel_row;
    logic [IDX_W-1:0]      i_pixel_col;
    logic                  o_result_strobe;
    logic [ITER_W-1:0]     o_iteration_count;
    logic                  o_escaped_white;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [COORD_W-1:0]    i_cfg_data;

    t_escape_scoreboard board = new();
    longint             cycle_count = 0;

    // Sender idle percentage per random phase. The receiver cannot stall the
    // strobe, so the receiver-stall phase reduces to no idling and the
    // both-sides phase to sender idling alone.
    int idle_plan[4] = '{0, 71, 0, 33};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mandelbrot_escape_pixel_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_pixel_row       (i_pixel_row),
        .i_pixel_col       (i_pixel_col),
        .o_result_strobe   (o_result_strobe),
        .o_iteration_count (o_iteration_count),
        .o_escaped_white   (o_escaped_white),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Monitor: sample every transfer on the edge that completes it
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // check before noting, so a result never pairs with a same-edge command
            if (o_result_strobe)
                board.check_result(o_iteration_count, o_escaped_white);
            if (start && !busy)
                board.note_pixel(i_pixel_row, i_pixel_col);
            if (i_cfg_valid && o_cfg_ready)
                board.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Issue one pixel, optionally after an idle gap; leave start high so a
    // following pixel can transfer back to back.
    task automatic send_pixel(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                              input int idle_pct);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 6);
        if (gap > 0) begin
            // drop start and scramble the ignored payload while idle
            start       <= 1'b0;
            i_pixel_row <= IDX_W'($urandom);
            i_pixel_col <= IDX_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_pixel_row <= row;
        i_pixel_col <= col;
        do @(posedge i_clk); while (busy);
    endtask

    // Hold the sender until every pending pixel has returned its result.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // One register transfer; keep valid high unless this is the last write.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COORD_W-1:0] data, input bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input longint xo, input longint yo, input longint xs,
                                input longint ys, input int limit);
        write_cfg(CFG_X_ORIGIN, COORD_W'(xo), 1'b0);
        write_cfg(CFG_Y_ORIGIN, COORD_W'(yo), 1'b0);
        write_cfg(CFG_X_STEP,   COORD_W'(xs), 1'b0);
        write_cfg(CFG_Y_STEP,   COORD_W'(ys), 1'b0);
        write_cfg(CFG_MAX_ITER, COORD_W'(limit), 1'b1);
    endtask

    // Place a 256 x 256 view centered on a random point of the interesting
    // region (real -2.0 .. 0.5, imaginary -1.2 .. 1.2), random zoom and sign.
    task automatic program_view_near_set(input int limit);
        longint xs, ys, cx, cy;
        xs = $urandom_range(1 << 12, 1 << 22);
        ys = $urandom_range(1 << 12, 1 << 22);
        if ($urandom_range(1)) xs = -xs;
        if ($urandom_range(1)) ys = -ys;
        cx = longint'($urandom_range(0, 671088640)) - 536870912;
        cy = longint'($urandom_range(0, 644245094)) - 322122547;
        program_regs(cx - 128 * xs, cy - 128 * ys, xs, ys, limit);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_pixel_row <= '0;
        i_pixel_col <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset view: corners, bounded points and a fast escape
        send_pixel(8'd0,   8'd0,   0);
        send_pixel(8'd0,   8'd255, 0);
        send_pixel(8'd255, 8'd0,   0);
        send_pixel(8'd255, 8'd255, 0);
        send_pixel(8'd128, 8'd205, 0);  // next to the origin, stays bounded
        send_pixel(8'd128, 8'd0,   0);  // c = -2, orbit parks at 2 on the real axis
        send_pixel(8'd128, 8'd128, 0);  // c = -0.75, slow convergence
        send_pixel(8'd100, 8'd230, 0);
        drain_results();

        // Spare register indexes: the writes must be dropped
        for (int k = CFG_MAX_ITER + 1; k < 2 ** CFG_IDX_W; k++)
            write_cfg(CFG_IDX_W'(k), COORD_W'({$urandom, $urandom}),
                      k == 2 ** CFG_IDX_W - 1);
        send_pixel(8'd64,  8'd180, 0);
        send_pixel(8'd190, 8'd150, 0);
        drain_results();

        // Limit zero: no iteration, black
        program_regs(RESET_X_ORIGIN, RESET_Y_ORIGIN, RESET_STEP, RESET_STEP, 0);
        send_pixel(8'd128, 8'd205, 0);
        send_pixel(8'd0,   8'd0,   0);
        drain_results();

        // Limit one
        write_cfg(CFG_MAX_ITER, COORD_W'(1), 1'b1);
        send_pixel(8'd128, 8'd205, 0);
        send_pixel(8'd10,  8'd20,  0);
        drain_results();

        // Full limit, inside the set and near the boundary
        write_cfg(CFG_MAX_ITER, COORD_W'(255), 1'b1);
        send_pixel(8'd128, 8'd205, 0);
        send_pixel(8'd128, 8'd160, 0);
        drain_results();

        // Extreme coordinates: escape on the bound check after one iteration
        program_regs(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 255);
        send_pixel(8'd0,   8'd0,   0);
        send_pixel(8'd255, 8'd255, 0);
        send_pixel(8'd0,   8'd255, 0);
        drain_results();
        program_regs(COORD_MIN, COORD_MAX, 0, 0, 255);
        send_pixel(8'd7, 8'd9, 0);
        drain_results();

        // c = 0 everywhere: runs to the limit
        program_regs(0, 0, 0, 0, 200);
        send_pixel(8'd33, 8'd77, 0);

        // Random phases, each reprogramming every register while idle
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_results();
            case (p)
                0:       program_view_near_set(255);
                1:       program_view_near_set(1);
                2:       program_regs(longint'({$urandom, $urandom}),
                                      longint'({$urandom, $urandom}),
                                      longint'({$urandom, $urandom}),
                                      longint'({$urandom, $urandom}),
                                      $urandom_range(0, 255));
                3:       program_view_near_set(128);
                4:       program_view_near_set($urandom_range(0, 10));
                default: program_view_near_set($urandom_range(1, 80));
            endcase
            for (int k = 0; k < PHASE_PIXELS; k++) begin
                // run the first stretch of every 40 pixels without gaps
                send_pixel(IDX_W'($urandom), IDX_W'($urandom),
                           ((k % 40) < 10) ? 0 : idle_plan[p % 4]);
                if ($urandom_range(199) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
